// ===== src/dopt_pkg.sv =====
// Package for the digital output pulse timer.
// Holds phase, mode and register index codes and the shared field types.
// No dependencies.
package dopt_pkg;

   typedef logic [1:0]  phase_type;
   typedef logic [1:0]  mode_type;
   typedef logic [31:0] time_type;
   typedef logic [15:0] repeat_type;

   localparam phase_type PHASE_IDLE   = 2'd0;
   localparam phase_type PHASE_DELAY  = 2'd1;
   localparam phase_type PHASE_ACTIVE = 2'd2;
   localparam phase_type PHASE_DONE   = 2'd3;

   localparam mode_type MODE_DELAYED   = 2'd0;
   localparam mode_type MODE_IMMEDIATE = 2'd1;
   localparam mode_type MODE_GATED     = 2'd2;

   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_DATA_WIDTH = 32;

   typedef logic [2:0] reg_index_type;

   localparam reg_index_type REG_MODE            = 3'd0;
   localparam reg_index_type REG_INVERT          = 3'd1;
   localparam reg_index_type REG_DELAY_BEFORE_ON = 3'd2;
   localparam reg_index_type REG_ACTIVE_DURATION = 3'd3;
   localparam reg_index_type REG_REPEAT_LIMIT    = 3'd4;

endpackage

// ===== src/dopt_channels.sv =====
// Handshake channels of the digital output pulse timer.
// Depends on dopt_pkg for the field types.
interface dopt_req_if;
   logic              valid;
   logic              ready;
   logic              turn_on;
   logic              turn_off;
   dopt_pkg::time_type now_ms;

   modport source (output valid, output turn_on, output turn_off, output now_ms,
                   input ready);
   modport sink   (input valid, input turn_on, input turn_off, input now_ms,
                   output ready);
endinterface

interface dopt_rsp_if;
   logic               valid;
   logic               ready;
   logic               turn_on_seen;
   logic               turn_off_seen;
   logic               reset_override;
   logic               effective_output;
   logic               rising_edge;
   dopt_pkg::time_type  pulse_count;
   dopt_pkg::phase_type phase;

   modport source (output valid, output turn_on_seen, output turn_off_seen,
                   output reset_override, output effective_output, output rising_edge,
                   output pulse_count, output phase, input ready);
   modport sink   (input valid, input turn_on_seen, input turn_off_seen,
                   input reset_override, input effective_output, input rising_edge,
                   input pulse_count, input phase, output ready);
endinterface

// ===== src/digital_output_pulse_timer_unit.sv =====
// Top level of the digital output pulse timer: mission state machine, pulse
// counter, result register and APB-style register port.
// Depends on dopt_pkg and the channel interfaces in dopt_channels.sv.
//
//   Channel   Direction  Carries
//   req_bus   in         turn_on, turn_off, now_ms (one scan tick per transfer)
//   rsp_bus   out        echoes, effective_output, rising_edge, pulse_count, phase
//   csr_*     in/out     mode, invert, delay_before_on, active_duration, repeat_limit
//
// One transfer per cycle unless stalled; each result appears in the next cycle.
// The state update is two 32-bit subtract-and-compare paths and a few muxes.
// A request is taken whenever the result register is empty or being drained.
// Reset clears the state, the registers and the result valid.
module digital_output_pulse_timer_unit (
   input  logic                                clock,
   input  logic                                reset,
   dopt_req_if.sink                            req_bus,
   dopt_rsp_if.source                          rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [dopt_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [dopt_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output logic [dopt_pkg::CSR_DATA_WIDTH-1:0] csr_prdata,
   output logic                                csr_pready
);
   import dopt_pkg::*;

   mode_type      mode_ff;
   logic          invert_ff;
   time_type      delay_ff;
   time_type      duration_ff;
   repeat_type    limit_ff;
   reg_index_type csr_index;
   logic          csr_write;

   phase_type  phase_ff, phase_in;
   time_type   on_start_ff, on_start_in;
   time_type   off_start_ff, off_start_in;
   repeat_type cycles_ff, cycles_in;
   time_type   count_ff, count_in;
   logic       level_ff, level_in;
   logic       edge_in;
   logic       mission;
   logic       eff;
   logic       accept;
   logic       rsp_valid_ff;

   assign csr_pready = 1'b1;
   assign csr_index  = csr_paddr[CSR_ADDR_WIDTH-1:2];
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= MODE_DELAYED;
         invert_ff   <= 1'b0;
         delay_ff    <= '0;
         duration_ff <= '0;
         limit_ff    <= '0;
      end else if (csr_write) begin
         case (csr_index)
            REG_MODE:            mode_ff     <= csr_pwdata[1:0];
            REG_INVERT:          invert_ff   <= csr_pwdata[0];
            REG_DELAY_BEFORE_ON: delay_ff    <= csr_pwdata;
            REG_ACTIVE_DURATION: duration_ff <= csr_pwdata;
            REG_REPEAT_LIMIT:    limit_ff    <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_MODE:            csr_prdata = {30'd0, mode_ff};
         REG_INVERT:          csr_prdata = {31'd0, invert_ff};
         REG_DELAY_BEFORE_ON: csr_prdata = delay_ff;
         REG_ACTIVE_DURATION: csr_prdata = duration_ff;
         REG_REPEAT_LIMIT:    csr_prdata = {16'd0, limit_ff};
         default:             csr_prdata = '0;
      endcase
   end

   always_comb begin
      phase_in     = phase_ff;
      on_start_in  = on_start_ff;
      off_start_in = off_start_ff;
      cycles_in    = cycles_ff;
      count_in     = count_ff;
      level_in     = level_ff;
      edge_in      = 1'b0;
      mission      = 1'b0;
      eff          = 1'b0;
      if (req_bus.turn_off) begin
         phase_in     = PHASE_IDLE;
         on_start_in  = '0;
         off_start_in = '0;
         cycles_in    = '0;
         count_in     = '0;
         level_in     = invert_ff;
      end else begin
         if (req_bus.turn_on && (phase_ff == PHASE_IDLE || phase_ff == PHASE_DONE)) begin
            cycles_in = '0;
            if (mode_ff == MODE_IMMEDIATE) begin
               phase_in     = PHASE_ACTIVE;
               off_start_in = req_bus.now_ms;
            end else begin
               phase_in    = PHASE_DELAY;
               on_start_in = req_bus.now_ms;
            end
         end
         if (mode_ff == MODE_GATED && !req_bus.turn_on &&
             (phase_in == PHASE_DELAY || phase_in == PHASE_ACTIVE)) begin
            phase_in     = PHASE_IDLE;
            on_start_in  = '0;
            off_start_in = '0;
            cycles_in    = '0;
            level_in     = invert_ff;
         end else begin
            case (phase_in)
               PHASE_DELAY: begin
                  if (time_type'(req_bus.now_ms - on_start_in) >= delay_ff) begin
                     phase_in     = PHASE_ACTIVE;
                     off_start_in = req_bus.now_ms;
                     mission      = 1'b1;
                  end
               end
               PHASE_ACTIVE: begin
                  mission = 1'b1;
                  if (duration_ff != '0 &&
                      time_type'(req_bus.now_ms - off_start_in) >= duration_ff) begin
                     if (cycles_in != '1) begin
                        cycles_in = cycles_in + 16'd1;
                     end
                     mission = 1'b0;
                     if (limit_ff != '0 && cycles_in >= limit_ff) begin
                        phase_in = PHASE_DONE;
                     end else begin
                        phase_in    = PHASE_DELAY;
                        on_start_in = req_bus.now_ms;
                     end
                  end
               end
               default: ;
            endcase
            eff = mission ^ invert_ff;
            if (!level_ff && eff) begin
               count_in = count_ff + 32'd1;
               edge_in  = 1'b1;
            end
            level_in = eff;
         end
      end
   end

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_IDLE;
         on_start_ff  <= '0;
         off_start_ff <= '0;
         cycles_ff    <= '0;
         count_ff     <= '0;
         level_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff     <= phase_in;
            on_start_ff  <= on_start_in;
            off_start_ff <= off_start_in;
            cycles_ff    <= cycles_in;
            count_ff     <= count_in;
            level_ff     <= level_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_bus.turn_on_seen     <= req_bus.turn_on;
         rsp_bus.turn_off_seen    <= req_bus.turn_off;
         rsp_bus.reset_override   <= req_bus.turn_on && req_bus.turn_off;
         rsp_bus.effective_output <= level_in;
         rsp_bus.rising_edge      <= edge_in;
         rsp_bus.pulse_count      <= count_in;
         rsp_bus.phase            <= phase_in;
      end
   end

   assign rsp_bus.valid = rsp_valid_ff;

endmodule

// ===== src/dopt_checker.sv =====
// Port-level checks for the digital output pulse timer, bound to the top level.
// Depends on dopt_pkg and digital_output_pulse_timer_unit.
module dopt_checker (
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic                turn_on_seen,
   input logic                turn_off_seen,
   input logic                reset_override,
   input logic                effective_output,
   input logic                rising_edge,
   input dopt_pkg::time_type  pulse_count,
   input dopt_pkg::phase_type phase
);
   import dopt_pkg::*;

   // A stalled result transfer keeps its valid, count, phase, output and edge flag.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(pulse_count) && $stable(phase)
         && $stable(effective_output) && $stable(rising_edge))
      else $error("stalled result changed");

   // A turn-off leaves the block idle with a cleared count and no edge.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && turn_off_seen |-> phase == PHASE_IDLE && pulse_count == '0 && !rising_edge)
      else $error("turn-off did not clear the mission");

   // A counted edge means the output is high.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rising_edge |-> effective_output)
      else $error("rising edge with low output");

   // The override flag is exactly both conditions together.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> reset_override == (turn_on_seen && turn_off_seen))
      else $error("override flag mismatch");

   // No result is offered in the cycle after reset.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind digital_output_pulse_timer_unit dopt_checker u_dopt_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .turn_on_seen     (rsp_bus.turn_on_seen),
   .turn_off_seen    (rsp_bus.turn_off_seen),
   .reset_override   (rsp_bus.reset_override),
   .effective_output (rsp_bus.effective_output),
   .rising_edge      (rsp_bus.rising_edge),
   .pulse_count      (rsp_bus.pulse_count),
   .phase            (rsp_bus.phase)
);

// ===== test/dopt_checker.sv =====
`timescale 1ns / 1ps
// Result checker for the digital output pulse timer: mirrors the register writes,
// predicts one result per accepted scan tick and compares it with the result channel.
// Depends on dopt_pkg and the channel interfaces in dopt_channels.sv.
module dopt_scoreboard (
   input  logic                                clock,
   input  logic                                reset,
   dopt_req_if                                 req_bus,
   dopt_rsp_if                                 rsp_bus,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic                                csr_pready,
   input  logic [dopt_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [dopt_pkg::CSR_DATA_WIDTH-1:0] csr_pwdata,
   output int                                  error_count,
   output int                                  pending_count
);
   import dopt_pkg::*;

   typedef struct packed {
      logic      turn_on_seen;
      logic      turn_off_seen;
      logic      reset_override;
      logic      effective_output;
      logic      rising_edge;
      time_type  pulse_count;
      phase_type phase;
   } tick_result_type;

   mode_type   cfg_mode;
   logic       cfg_invert;
   time_type   cfg_delay;
   time_type   cfg_duration;
   repeat_type cfg_repeat_limit;

   phase_type  timer_phase;
   time_type   on_start;
   time_type   off_start;
   repeat_type cycles_done;
   time_type   edge_count;
   logic       level;
   logic       edge_seen;

   tick_result_type predicted_outputs[$];
   tick_result_type oldest;
   int failures = 0;
   int waiting = 0;

   assign error_count   = failures;
   assign pending_count = waiting;

   function automatic void drop_to_idle(input logic clear_count);
      edge_seen   = 1'b0;
      on_start    = '0;
      off_start   = '0;
      cycles_done = '0;
      if (clear_count) begin
         edge_count = '0;
      end
      timer_phase = PHASE_IDLE;
      level       = cfg_invert;
   endfunction

   function automatic tick_result_type advance_timer(input logic on, input logic off,
                                                     input time_type now);
      tick_result_type r;
      logic prior_level;
      logic mission;
      logic level_next;
      prior_level = level;
      mission = 1'b0;
      r.turn_on_seen   = on;
      r.turn_off_seen  = off;
      r.reset_override = on & off;
      if (off) begin
         drop_to_idle(1'b1);
      end else begin
         edge_seen = 1'b0;
         if (on && (timer_phase == PHASE_IDLE || timer_phase == PHASE_DONE)) begin
            cycles_done = '0;
            if (cfg_mode == MODE_IMMEDIATE) begin
               timer_phase = PHASE_ACTIVE;
               off_start = now;
            end else begin
               timer_phase = PHASE_DELAY;
               on_start = now;
            end
         end
         if (cfg_mode == MODE_GATED && !on &&
             (timer_phase == PHASE_DELAY || timer_phase == PHASE_ACTIVE)) begin
            drop_to_idle(1'b0);
         end else begin
            if (timer_phase == PHASE_DELAY) begin
               if (cfg_delay == '0 || time_type'(now - on_start) >= cfg_delay) begin
                  timer_phase = PHASE_ACTIVE;
                  off_start = now;
                  mission = 1'b1;
               end
            end else if (timer_phase == PHASE_ACTIVE) begin
               mission = 1'b1;
               if (cfg_duration != '0 && time_type'(now - off_start) >= cfg_duration) begin
                  if (cycles_done != 16'hFFFF) begin
                     cycles_done = cycles_done + 16'd1;
                  end
                  mission = 1'b0;
                  if (cfg_repeat_limit != '0 && cycles_done >= cfg_repeat_limit) begin
                     timer_phase = PHASE_DONE;
                  end else begin
                     timer_phase = PHASE_DELAY;
                     on_start = now;
                  end
               end
            end
            level_next = mission ^ cfg_invert;
            if (!prior_level && level_next) begin
               edge_count = edge_count + 32'd1;
               edge_seen = 1'b1;
            end
            level = level_next;
         end
      end
      r.effective_output = level;
      r.rising_edge      = edge_seen;
      r.pulse_count      = edge_count;
      r.phase            = timer_phase;
      return r;
   endfunction

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         cfg_mode         = MODE_DELAYED;
         cfg_invert       = 1'b0;
         cfg_delay        = '0;
         cfg_duration     = '0;
         cfg_repeat_limit = '0;
         timer_phase      = PHASE_IDLE;
         on_start         = '0;
         off_start        = '0;
         cycles_done      = '0;
         edge_count       = '0;
         level            = 1'b0;
         edge_seen        = 1'b0;
         predicted_outputs.delete();
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[CSR_ADDR_WIDTH-1:2]))
               REG_MODE:            cfg_mode         = mode_type'(csr_pwdata[1:0]);
               REG_INVERT:          cfg_invert       = csr_pwdata[0];
               REG_DELAY_BEFORE_ON: cfg_delay        = csr_pwdata;
               REG_ACTIVE_DURATION: cfg_duration     = csr_pwdata;
               REG_REPEAT_LIMIT:    cfg_repeat_limit = csr_pwdata[15:0];
               default: ;
            endcase
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (predicted_outputs.size() == 0) begin
               $error("result transfer with no expected result waiting");
               failures++;
            end else begin
               oldest = predicted_outputs.pop_front();
               check_field("turn_on_seen", 32'(oldest.turn_on_seen),
                           32'(rsp_bus.turn_on_seen));
               check_field("turn_off_seen", 32'(oldest.turn_off_seen),
                           32'(rsp_bus.turn_off_seen));
               check_field("reset_override", 32'(oldest.reset_override),
                           32'(rsp_bus.reset_override));
               check_field("effective_output", 32'(oldest.effective_output),
                           32'(rsp_bus.effective_output));
               check_field("rising_edge", 32'(oldest.rising_edge),
                           32'(rsp_bus.rising_edge));
               check_field("pulse_count", oldest.pulse_count, rsp_bus.pulse_count);
               check_field("phase", 32'(oldest.phase), 32'(rsp_bus.phase));
            end
         end
         if (req_bus.valid && req_bus.ready) begin
            predicted_outputs.push_back(advance_timer(req_bus.turn_on, req_bus.turn_off,
                                                      req_bus.now_ms));
         end
      end
      waiting = predicted_outputs.size();
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench top for the digital output pulse timer: clock, reset, register writes,
// scan tick stimulus with random idling and stalls, and the final verdict.
// Depends on dopt_pkg, dopt_channels.sv, the block itself and dopt_scoreboard.
module tb;
   import dopt_pkg::*;

   localparam mode_type MODE_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 600000;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [CSR_ADDR_WIDTH-1:0] csr_paddr;
   logic [CSR_DATA_WIDTH-1:0] csr_pwdata;
   logic [CSR_DATA_WIDTH-1:0] csr_prdata;
   logic csr_pready;
   int error_count;
   int pending_count;
   int send_idle_pct;
   int stall_pct;
   int cycle_count;

   dopt_req_if req ();
   dopt_rsp_if rsp ();

   digital_output_pulse_timer_unit dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req),
      .rsp_bus     (rsp),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   dopt_scoreboard scoreboard (
      .clock         (clock),
      .reset         (reset),
      .req_bus       (req),
      .rsp_bus       (rsp),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_pready    (csr_pready),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("TB_ERROR");
      $finish;
   end

   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp.ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   task automatic send_tick(input logic on, input logic off, input time_type now);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid    <= 1'b1;
      req.turn_on  <= on;
      req.turn_off <= off;
      req.now_ms   <= now;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
   endtask

   task automatic wait_for_results();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(input reg_index_type index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input mode_type mode, input logic invert, input time_type dly,
                                 input time_type dur, input repeat_type limit);
      write_register(REG_MODE, 32'(mode));
      write_register(REG_INVERT, 32'(invert));
      write_register(REG_DELAY_BEFORE_ON, dly);
      write_register(REG_ACTIVE_DURATION, dur);
      write_register(REG_REPEAT_LIMIT, 32'(limit));
   endtask

   function automatic time_type pick_interval();
      int roll;
      roll = $urandom_range(99);
      if (roll < 25) return '0;
      if (roll < 75) return time_type'($urandom_range(6, 1));
      if (roll < 90) return time_type'($urandom);
      return 32'hFFFF_FFFF;
   endfunction

   task automatic randomize_settings();
      int roll;
      repeat_type limit;
      roll = $urandom_range(99);
      if (roll < 30) limit = '0;
      else if (roll < 80) limit = repeat_type'($urandom_range(4, 1));
      else if (roll < 90) limit = 16'hFFFF;
      else limit = repeat_type'($urandom_range(65535));
      apply_settings(mode_type'($urandom_range(3)), logic'($urandom_range(1)),
                     pick_interval(), pick_interval(), limit);
   endtask

   // Mostly a slowly advancing clock with turn-on held for stretches, so that
   // missions run through their phases; now and then a jump or a turn-off.
   task automatic run_scan_burst(input int count);
      time_type now;
      logic on;
      int roll;
      roll = $urandom_range(3);
      if (roll < 2) now = $urandom;
      else if (roll == 2) now = 32'hFFFF_FFFF - time_type'($urandom_range(40));
      else now = time_type'($urandom_range(100));
      on = logic'($urandom_range(1));
      repeat (count) begin
         roll = $urandom_range(19);
         if (roll == 0) now = $urandom;
         else if (roll < 3) now = now + time_type'($urandom_range(1000));
         else now = now + time_type'($urandom_range(3));
         if (on) on = ($urandom_range(9) != 0);
         else on = ($urandom_range(2) == 0);
         send_tick(on, ($urandom_range(24) == 0), now);
      end
   endtask

   initial begin
      reset       <= 1'b1;
      req.valid   <= 1'b0;
      req.turn_on <= 1'b0;
      req.turn_off <= 1'b0;
      req.now_ms  <= '0;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= '0;
      csr_pwdata  <= '0;
      send_idle_pct = 0;
      stall_pct = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Settings after reset: delayed start, no delay, active forever.
      send_tick(1'b0, 1'b0, 32'd0);
      send_tick(1'b1, 1'b1, 32'hFFFF_FFFF);
      send_tick(1'b1, 1'b0, 32'd5);
      send_tick(1'b0, 1'b0, 32'd6000);
      send_tick(1'b0, 1'b1, 32'd7);
      wait_for_results();

      // Largest intervals, with the clock wrapping through zero.
      apply_settings(MODE_IMMEDIATE, 1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
      send_tick(1'b1, 1'b0, 32'hFFFF_FFF0);
      send_tick(1'b0, 1'b0, 32'h0000_0005);
      send_tick(1'b0, 1'b0, 32'hFFFF_FFEF);
      send_tick(1'b0, 1'b0, 32'h7FFF_FFFF);
      send_tick(1'b1, 1'b1, 32'd0);
      wait_for_results();

      // Gated mode: finish, restart from finished, abort from on-delay and active.
      apply_settings(MODE_GATED, 1'b0, 32'd3, 32'd2, 16'd1);
      send_tick(1'b1, 1'b0, 32'd10);
      send_tick(1'b1, 1'b0, 32'd13);
      send_tick(1'b1, 1'b0, 32'd15);
      send_tick(1'b1, 1'b0, 32'd16);
      send_tick(1'b0, 1'b0, 32'd17);
      send_tick(1'b1, 1'b0, 32'd20);
      send_tick(1'b1, 1'b0, 32'd23);
      send_tick(1'b0, 1'b0, 32'd24);
      wait_for_results();

      // The unused mode code behaves as delayed start.
      apply_settings(MODE_UNUSED, 1'b1, 32'd0, 32'd0, 16'd2);
      send_tick(1'b1, 1'b0, 32'd100);
      send_tick(1'b0, 1'b0, 32'd200);
      send_tick(1'b0, 1'b1, 32'd300);
      wait_for_results();

      for (int phase_sel = 0; phase_sel < 4; phase_sel++) begin
         case (phase_sel)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 70; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 70; end
            default: begin send_idle_pct = 30; stall_pct = 30; end
         endcase
         repeat (6) begin
            randomize_settings();
            run_scan_burst(48);
            wait_for_results();
         end
      end

      if (error_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
